// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ----- rtl/core/sab_pkg.sv -----
// Package with the shared types of the suffix automaton builder.
package sab_pkg;
	localparam int SymW   = 5;
	localparam int StateW = 13;
	localparam int CountW = 14;

	typedef struct packed {
		logic [SymW-1:0] symbol;
		logic            restart;
	} sab_in_t;

	typedef struct packed {
		logic [StateW-1:0] last_state;
		logic [StateW-1:0] suffix_link_of_last;
		logic [CountW-1:0] state_count;
		logic              made_clone;
		logic              overflow;
	} sab_out_t;
endpackage

// ----- rtl/core/sab_in_if.sv -----
// Valid/ready input channel interface for the suffix automaton builder.
interface sab_in_if import sab_pkg::*; ();
	logic    valid;
	logic    ready;
	sab_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/sab_out_if.sv -----
// Valid/ready result channel interface for the suffix automaton builder.
interface sab_out_if import sab_pkg::*; ();
	logic     valid;
	logic     ready;
	sab_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/suffix_automaton_builder.sv -----
// Top level of the suffix automaton builder: sequencer and state memories.
// Usage: one input word (symbol, restart) on channel in appends one letter to the
// automaton and yields exactly one result word on channel out.
// A word is accepted when valid and ready are high at a rising edge of clk.
// The block works on one word at a time: ready is high only while the sequencer idles.
// Steps after acceptance: the last state's length is read, the new state's
// transition row is cleared one entry per step, and the first suffix-link walk
// reads, checks and follows the link of each state it visits (the last visit
// follows no link); the state that was found is then inspected. A clone copies
// the row (a read and a write per entry) and walks the redirect chain the same
// way. The single-ported transition memory, touched one entry per step, sets
// this pace. An ignored symbol stops at the first clear step and skips the walks.
// A restart first clears the root's row. After reset the root row is cleared
// the same way, and ready rises only when that is done.
// Without stalls the sequencer returns to idle as the result is registered, so
// the next word can be accepted in the cycle after.
// When the receiver stalls the result stays in the output register. The block may
// still accept and work on the next word, but holds it in its final step until the
// waiting result has been taken.
// Ignored symbols (outside the alphabet, or string at MAX_LENGTH) report the
// automaton without the letter, with overflow set; a restart on the word still applies.
module suffix_automaton_builder import sab_pkg::*; #(
	parameter int MAX_LENGTH = 4096,
	parameter int ALPHABET   = 26
) (
	input logic        clk,
	input logic        arst_n,
	sab_in_if.sink     in,
	sab_out_if.source  out
);
	localparam int MaxStates = 2 * MAX_LENGTH;
	localparam int SW        = $clog2(MaxStates);
	localparam int CW        = $clog2(MaxStates + 1);
	localparam int LW        = $clog2(MAX_LENGTH + 1);
	localparam int AW        = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
	localparam int TW        = SW + AW;
	localparam int TDepth    = MaxStates * (2 ** AW);

	typedef enum logic [4:0] {
		ST_INIT, ST_IDLE, ST_RCLR, ST_DECIDE, ST_FCLR,
		ST_W1RD, ST_W1CHK, ST_W1LNK,
		ST_QLEN, ST_QCHK, ST_CPRD, ST_CPWR,
		ST_W2RD, ST_W2CHK, ST_W2LNK, ST_FIN, ST_RES, ST_OUT
	} state_t;

	// Memories: transition row per state, length and link per state.
	logic [SW-1:0] tmem [TDepth];
	logic [LW-1:0] lmem [MaxStates];
	logic [SW-1:0] kmem [MaxStates];

	logic [TW-1:0] t_addr;
	logic          t_we;
	logic [SW-1:0] t_wd, t_rd_q;
	logic [SW-1:0] l_addr;
	logic          l_we;
	logic [LW-1:0] l_wd, l_rd_q;
	logic [SW-1:0] k_addr;
	logic          k_we;
	logic [SW-1:0] k_wd, k_rd_q;

	always_ff @(posedge clk) begin
		if (t_we) tmem[t_addr] <= t_wd;
		t_rd_q <= tmem[t_addr];
		if (l_we) lmem[l_addr] <= l_wd;
		l_rd_q <= lmem[l_addr];
		if (k_we) kmem[k_addr] <= k_wd;
		k_rd_q <= kmem[k_addr];
	end

	state_t        st_q;
	logic [AW-1:0] col_q;
	logic [AW-1:0] c_q;
	logic [SW-1:0] last_q, fresh_q, p_q, q_q, cl_q, lnk_q;
	logic [CW-1:0] used_q;
	logic [LW-1:0] lastlen_q, plen_q;
	logic          clone_q, ign_q, found_q;
	sab_out_t      res_q;
	logic          ovalid_q;

	logic [SW-1:0] res_addr_q;

	// Memory port control.
	always_comb begin
		t_addr = {p_q, c_q};
		t_we   = 1'b0;
		t_wd   = '0;
		l_addr = p_q;
		l_we   = 1'b0;
		l_wd   = '0;
		k_addr = p_q;
		k_we   = 1'b0;
		k_wd   = '0;
		case (st_q)
			ST_INIT, ST_RCLR: begin
				t_addr = {{SW{1'b0}}, col_q};
				t_we   = 1'b1;
				l_addr = '0;
				l_we   = 1'b1;
			end
			ST_DECIDE: begin
				l_addr = last_q;
			end
			ST_FCLR: begin
				t_addr = {fresh_q, col_q};
				t_we   = 1'b1;
				l_addr = fresh_q;
				l_we   = 1'b1;
				l_wd   = LW'(lastlen_q + 1'b1);
			end
			ST_W1CHK: begin
				t_we = (t_rd_q == '0);
				t_wd = fresh_q;
			end
			ST_QLEN: begin
				l_addr = t_rd_q;
				k_addr = t_rd_q;
			end
			ST_QCHK: begin
				t_addr = {q_q, col_q};
			end
			ST_CPRD: begin
				t_addr = {q_q, col_q};
			end
			ST_CPWR: begin
				t_addr = {cl_q, col_q};
				t_we   = 1'b1;
				t_wd   = t_rd_q;
			end
			ST_W2CHK: begin
				t_we = (t_rd_q == q_q);
				t_wd = cl_q;
			end
			ST_FIN: begin
				k_addr = fresh_q;
				k_we   = 1'b1;
				k_wd   = !found_q ? '0 : (clone_q ? cl_q : q_q);
			end
			ST_RES, ST_OUT: begin
				k_addr = res_addr_q;
			end
			default: ;
		endcase
		// The clone's length and link are written on the first copy read, and the
		// original's new link on the first copy write, so the redirect walk reads
		// only the links of the states it visits.
		if (st_q == ST_CPRD && col_q == '0) begin
			l_addr = cl_q;
			l_we   = 1'b1;
			l_wd   = LW'(plen_q + 1'b1);
			k_addr = cl_q;
			k_we   = 1'b1;
			k_wd   = lnk_q;
		end
		if (st_q == ST_CPWR && col_q == '0) begin
			k_addr = q_q;
			k_we   = 1'b1;
			k_wd   = cl_q;
		end
	end

	assign in.ready = (st_q == ST_IDLE);
	assign out.valid = ovalid_q;
	assign out.data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_INIT;
			col_q    <= '0;
			used_q   <= CW'(1);
			last_q   <= '0;
			ovalid_q <= 1'b0;
			clone_q  <= 1'b0;
			ign_q    <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			case (st_q)
				ST_INIT: begin
					col_q <= col_q + 1'b1;
					if (col_q == AW'(ALPHABET - 1)) begin
						col_q <= '0;
						st_q  <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in.valid) begin
						c_q     <= AW'(in.data.symbol);
						ign_q   <= (32'(in.data.symbol) >= ALPHABET);
						clone_q <= 1'b0;
						found_q <= 1'b0;
						col_q   <= '0;
						if (in.data.restart) begin
							used_q <= CW'(1);
							last_q <= '0;
							st_q   <= ST_RCLR;
						end else begin
							st_q <= ST_DECIDE;
						end
					end
				end
				ST_RCLR: begin
					col_q <= col_q + 1'b1;
					if (col_q == AW'(ALPHABET - 1)) begin
						col_q <= '0;
						st_q  <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					// The last state's length is read here and checked on the first
					// clear step.
					st_q <= ST_FCLR;
					col_q <= '0;
					fresh_q <= used_q[SW-1:0];
					p_q <= last_q;
				end
				ST_FCLR: begin
					if (col_q == '0) begin
						lastlen_q <= l_rd_q;
						if (ign_q || 32'(l_rd_q) >= MAX_LENGTH) begin
							ign_q <= 1'b1;
							res_addr_q <= last_q;
							st_q <= ST_RES;
						end
					end
					if (!(col_q == '0 && (ign_q || 32'(l_rd_q) >= MAX_LENGTH))) begin
						col_q <= col_q + 1'b1;
						if (col_q == AW'(ALPHABET - 1)) begin
							col_q  <= '0;
							used_q <= used_q + 1'b1;
							st_q   <= ST_W1RD;
						end
					end
				end
				ST_W1RD: st_q <= ST_W1CHK;
				ST_W1CHK: begin
					plen_q <= l_rd_q;
					lnk_q  <= k_rd_q;
					if (t_rd_q != '0) begin
						found_q <= 1'b1;
						st_q    <= ST_QLEN;
					end else if (p_q == '0) begin
						st_q <= ST_FIN;
					end else begin
						st_q <= ST_W1LNK;
					end
				end
				ST_W1LNK: begin
					p_q  <= lnk_q;
					st_q <= ST_W1RD;
				end
				ST_QLEN: begin
					q_q  <= t_rd_q;
					st_q <= ST_QCHK;
				end
				ST_QCHK: begin
					if (LW'(plen_q + 1'b1) == l_rd_q) begin
						st_q <= ST_FIN;
					end else begin
						clone_q <= 1'b1;
						cl_q    <= used_q[SW-1:0];
						used_q  <= used_q + 1'b1;
						lnk_q   <= k_rd_q;
						col_q   <= '0;
						st_q    <= ST_CPRD;
					end
				end
				ST_CPRD: st_q <= ST_CPWR;
				ST_CPWR: begin
					col_q <= col_q + 1'b1;
					st_q  <= ST_CPRD;
					if (col_q == AW'(ALPHABET - 1)) begin
						col_q <= '0;
						st_q  <= ST_W2RD;
					end
				end
				ST_W2RD: st_q <= ST_W2CHK;
				ST_W2CHK: begin
					lnk_q <= k_rd_q;
					if (t_rd_q != q_q || p_q == '0) st_q <= ST_FIN;
					else st_q <= ST_W2LNK;
				end
				ST_W2LNK: begin
					p_q  <= lnk_q;
					st_q <= ST_W2RD;
				end
				ST_FIN: begin
					last_q     <= fresh_q;
					res_addr_q <= fresh_q;
					st_q       <= ST_RES;
				end
				ST_RES: st_q <= ST_OUT;
				ST_OUT: begin
					if (!ovalid_q) begin
						res_q.last_state <= StateW'(res_addr_q);
						res_q.suffix_link_of_last <= (res_addr_q == '0) ? '0
							: StateW'(k_rd_q);
						res_q.state_count <= CountW'(used_q);
						res_q.made_clone  <= clone_q;
						res_q.overflow    <= ign_q;
						ovalid_q <= 1'b1;
						st_q     <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
			if (ovalid_q && out.ready) ovalid_q <= 1'b0;
		end
	end
endmodule

// ----- rtl/core/sab_checker.sv -----
// Port-level checker for the suffix automaton builder, bound to the top level.
`include "assert_macros.svh"
module sab_checker import sab_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input sab_out_t out_data
);
	`CHK_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`CHK_IMPLY(a_count_nonzero, clk, arst_n, out_valid, out_data.state_count != '0)
	`CHK_IMPLY(a_clone_not_ignored, clk, arst_n, out_valid,
		!(out_data.made_clone && out_data.overflow))
	`CHK_IMPLY(a_root_link, clk, arst_n, out_valid && out_data.last_state == '0,
		out_data.suffix_link_of_last == '0)
endmodule

bind suffix_automaton_builder sab_checker u_sab_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in.valid),
	.in_ready (in.ready),
	.out_valid(out.valid),
	.out_ready(out.ready),
	.out_data (out.data)
);

// ----- test/suffix_automaton_builder_tb.sv -----
// Self-checking testbench for the suffix automaton builder: directed rows and random symbols.
`timescale 1ns / 100ps

module suffix_automaton_builder_tb;
	import sab_pkg::*;

	localparam int MaxLength = 4096;
	localparam int Alphabet  = 26;
	localparam int MaxStates = 2 * MaxLength;
	localparam int RandomWords = 1636;

	// One row of the directed part. When known is set, the expected result
	// is typed into the row; otherwise the automaton predictor supplies it.
	typedef struct {
		logic [SymW-1:0] symbol;
		logic            restart;
		bit              known;
		sab_out_t        result;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sab_in_if  in_ch ();
	sab_out_if out_ch ();

	suffix_automaton_builder #(
		.MAX_LENGTH(MaxLength),
		.ALPHABET(Alphabet)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in(in_ch.sink),
		.out(out_ch.source)
	);

	always #5 clk = ~clk;

	// The predictor keeps its own copy of the automaton. A transition value
	// of zero means no edge, since the root is never a target.
	int unsigned next_state [MaxStates][Alphabet];
	int unsigned longest_len [MaxStates];
	int unsigned link_of [MaxStates];
	int unsigned live_states;
	int unsigned tail_state;

	sab_out_t expected_results [$];
	int mismatches = 0;
	bit check_failed = 1'b0;

	// Clears the automaton back to the lone root state.
	function automatic void clear_automaton();
		for (int a = 0; a < Alphabet; a++) next_state[0][a] = 0;
		longest_len[0] = 0;
		link_of[0] = 0;
		live_states = 1;
		tail_state = 0;
	endfunction

	function automatic void ref_init();
		for (int s = 0; s < MaxStates; s++) begin
			longest_len[s] = 0;
			link_of[s] = 0;
		end
		clear_automaton();
	endfunction

	// Appends one letter by online construction and reports a clone.
	function automatic bit extend_automaton(int unsigned c);
		int unsigned fresh;
		int unsigned p;
		int unsigned q;
		int unsigned cl;
		bit found;
		bit cloned;
		fresh = live_states;
		live_states++;
		p = tail_state;
		found = 1'b0;
		cloned = 1'b0;
		longest_len[fresh] = longest_len[tail_state] + 1;
		for (int a = 0; a < Alphabet; a++) next_state[fresh][a] = 0;
		forever begin
			if (next_state[p][c] != 0) begin
				found = 1'b1;
				break;
			end
			next_state[p][c] = fresh;
			if (p == 0) break;
			p = link_of[p];
		end
		if (!found) begin
			link_of[fresh] = 0;
		end else begin
			q = next_state[p][c];
			if (longest_len[p] + 1 == longest_len[q]) begin
				link_of[fresh] = q;
			end else begin
				cl = live_states;
				live_states++;
				cloned = 1'b1;
				longest_len[cl] = longest_len[p] + 1;
				link_of[cl] = link_of[q];
				for (int a = 0; a < Alphabet; a++) next_state[cl][a] = next_state[q][a];
				forever begin
					if (next_state[p][c] != q) break;
					next_state[p][c] = cl;
					if (p == 0) break;
					p = link_of[p];
				end
				link_of[q] = cl;
				link_of[fresh] = cl;
			end
		end
		tail_state = fresh;
		return cloned;
	endfunction

	// Predicts the result word for one input word and updates the copy.
	function automatic sab_out_t predict_append(logic [SymW-1:0] sym, logic rst);
		sab_out_t r;
		bit cloned;
		bit ignored;
		cloned = 1'b0;
		ignored = 1'b0;
		if (rst) clear_automaton();
		if (sym >= Alphabet || longest_len[tail_state] >= MaxLength) begin
			ignored = 1'b1;
		end else begin
			cloned = extend_automaton(sym);
		end
		r.last_state = tail_state[StateW-1:0];
		r.suffix_link_of_last = (tail_state == 0) ? '0 : link_of[tail_state][StateW-1:0];
		r.state_count = live_states[CountW-1:0];
		r.made_clone = cloned;
		r.overflow = ignored;
		return r;
	endfunction

	function automatic sab_out_t mk(int ls, int sl, int sc, bit cl, bit ov);
		sab_out_t r;
		r.last_state = StateW'(ls);
		r.suffix_link_of_last = StateW'(sl);
		r.state_count = CountW'(sc);
		r.made_clone = cl;
		r.overflow = ov;
		return r;
	endfunction

	// Appends one predicted word at the tail of the expected queue.
	function automatic void queue_expected(sab_out_t r);
		expected_results.insert(expected_results.size(), r);
	endfunction

	// Drives one word and waits for its acceptance. Valid stays high afterwards
	// so that a following word can go out back to back; a gap lowers it.
	// The model is advanced at the same time, so its copy stays in order.
	task automatic send_word(logic [SymW-1:0] sym, logic rst, bit known, sab_out_t typed);
		sab_out_t pred;
		pred = predict_append(sym, rst);
		if (known && pred !== typed) begin
			$display("directed row disagrees with the predictor: %p vs %p", typed, pred);
			check_failed = 1'b1;
		end
		queue_expected(pred);
		in_ch.valid <= 1'b1;
		in_ch.data <= '{symbol: sym, restart: rst};
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Sender gap between bursts: random, with long stretches of none.
	int burst_left = 0;
	task automatic maybe_gap();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 60) : 0;
			if (gap != 0) in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		burst_left--;
	endtask

	// Result side: sample at the rising edge, compare with the oldest entry.
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_results.size() == 0) begin
				check_failed = 1'b1;
				if (mismatches < 10) $display("unexpected result word %p", out_ch.data);
				mismatches++;
			end else begin
				sab_out_t e;
				e = expected_results.pop_front();
				if (out_ch.data !== e) begin
					check_failed = 1'b1;
					if (mismatches < 10)
						$display("result mismatch: expected %p, got %p", e, out_ch.data);
					mismatches++;
				end
			end
		end
	end

	// Receiver stalls follow their own pattern, with quiet stretches.
	int stall_phase = 0;
	always @(negedge clk) begin
		stall_phase = (stall_phase + 1) % 200;
		if (stall_phase < 50) out_ch.ready <= 1'b1;
		else out_ch.ready <= ($urandom_range(0, 3) != 0);
	end

	stim_row_t directed [] = '{
		'{5'd0, 1'b0, 1'b1, '0},   // first letter after reset
		'{5'd0, 1'b0, 1'b0, '0},   // repeated letter
		'{5'd25, 1'b0, 1'b0, '0},  // highest letter
		'{5'd0, 1'b0, 1'b0, '0},   // links back to the first state ("aaza")
		'{5'd26, 1'b0, 1'b0, '0},  // just outside the alphabet
		'{5'd31, 1'b0, 1'b1, '0},  // all ones, ignored
		'{5'd31, 1'b1, 1'b1, '0},  // restart with an ignored symbol
		'{5'd1, 1'b1, 1'b1, '0},   // restart then append
		'{5'd2, 1'b0, 1'b0, '0},
		'{5'd1, 1'b0, 1'b0, '0},
		'{5'd1, 1'b0, 1'b0, '0},   // repeated letter on "bcbb"
		'{5'd2, 1'b0, 1'b0, '0},
		'{5'd21, 1'b0, 1'b0, '0},
		'{5'd10, 1'b1, 1'b0, '0}
	};

	initial begin
		int n;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		ref_init();
		// Typed rows: values that follow from the construction at a glance.
		directed[0].result = mk(1, 0, 2, 0, 0);
		directed[5].result = mk(4, 1, 5, 0, 1);
		directed[6].result = mk(0, 0, 1, 0, 1);
		directed[7].result = mk(1, 0, 2, 0, 0);
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		foreach (directed[i]) begin
			maybe_gap();
			send_word(directed[i].symbol, directed[i].restart, directed[i].known,
				directed[i].result);
		end
		// Hold off until every expected result has come back.
		in_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		// Random part: mostly strings over small alphabets to force clones.
		n = 0;
		while (n < RandomWords) begin
			int k;
			int mode;
			logic [SymW-1:0] s;
			k = $urandom_range(0, 2);
			mode = (k == 0) ? 1 : (k == 1) ? 3 : 25;
			maybe_gap();
			if ($urandom_range(0, 39) == 0) s = SymW'($urandom_range(26, 31));
			else s = SymW'($urandom_range(0, mode));
			send_word(s, $urandom_range(0, 99) < 3, 1'b0, '0);
			n++;
		end
		in_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (!check_failed && expected_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#60ms;
		$display("status: fail");
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/sab_pkg.sv
rtl/core/sab_in_if.sv
rtl/core/sab_out_if.sv
rtl/core/suffix_automaton_builder.sv
rtl/core/sab_checker.sv
test/suffix_automaton_builder_tb.sv
